// ===== src/aws_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aws_pkg
// Shared constants, register codes and record types for the auction winner
// selection block.
// ----------------------------------------------------------------------------
package aws_pkg;

    // Block limits.
    localparam int MAX_ROBOTS = 16;
    localparam int MAX_TASKS  = 256;
    localparam int BID_BITS   = 32;

    // Field widths.
    localparam int TASK_W      = 8;
    localparam int ROBOT_W     = 4;
    localparam int BID_FIELD_W = 32;
    localparam int RCOUNT_W    = 5;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LC_MODE     = 2'd0,
        CFG_ROBOT_COUNT = 2'd1
    } cfg_reg_t;

    localparam logic                LC_MODE_RESET     = 1'b1;
    localparam logic [RCOUNT_W-1:0] ROBOT_COUNT_RESET = 5'd16;

    // Stream packing.
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 80;
    localparam int M_TUSER_W = 2;

    // Control flags of one record passed from the task tracker to the winner stage.
    typedef struct packed {
        logic cand;   // record carries a candidate winner
        logic close;  // candidate is a closed task of least-contested mode
        logic unc;    // closed task had a single valid bid
        logic rdone;  // last beat of the round
    } rec_ctrl_t;

endpackage : aws_pkg
`default_nettype wire

// ===== src/aws_task_tracker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aws_task_tracker
// Qualifies each bid beat, tracks lowest and second-lowest bids of the open
// task in least-contested mode, and registers one candidate record per beat.
// ----------------------------------------------------------------------------
module aws_task_tracker
    import aws_pkg::*;
#(
    parameter int BID_W = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                lc_mode,
    input  wire logic [RCOUNT_W-1:0] robot_count,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [TASK_W-1:0]   task_index,
    input  wire logic [ROBOT_W-1:0]  robot_index,
    input  wire logic [BID_W-1:0]    bid_value,
    input  wire logic                bid_valid,
    input  wire logic                task_done,
    input  wire logic                round_done,
    output logic                     rec_valid,
    input  wire logic                rec_take,
    output rec_ctrl_t                rec_ctrl,
    output logic [BID_W-1:0]         rec_bid,
    output logic [BID_W-1:0]         rec_margin,
    output logic [ROBOT_W-1:0]       rec_robot,
    output logic [TASK_W-1:0]        rec_task
);

    // Open task state.
    logic [BID_W-1:0]   low_reg;
    logic [BID_W-1:0]   sec_reg;
    logic               has_low_reg;
    logic               has_sec_reg;
    logic [ROBOT_W-1:0] robot_reg;
    logic               rec_valid_reg;
    rec_ctrl_t          rec_ctrl_reg;
    logic [BID_W-1:0]   rec_bid_reg;
    logic [BID_W-1:0]   rec_margin_reg;
    logic [ROBOT_W-1:0] rec_robot_reg;
    logic [TASK_W-1:0]  rec_task_reg;

    logic [BID_W-1:0]   low_next;
    logic [BID_W-1:0]   sec_next;
    logic               has_low_next;
    logic               has_sec_next;
    logic [ROBOT_W-1:0] robot_next;
    logic [BID_W-1:0]   margin_next;
    rec_ctrl_t          rec_ctrl_next;
    logic [BID_W-1:0]   rec_bid_next;
    logic [BID_W-1:0]   rec_margin_next;
    logic [ROBOT_W-1:0] rec_robot_next;

    logic [RCOUNT_W-1:0] robots_eff;
    logic                robot_ok;
    logic                task_ok;
    logic                lc;
    logic                valid_eff;
    logic                close_task;
    logic                in_fire;
    logic                new_low;
    logic                new_sec;
    logic [BID_W-1:0]    margin_low;
    logic [BID_W-1:0]    margin_sec;
    logic [BID_W-1:0]    margin_keep;

    // A new beat enters when the record slot is free or being drained.
    assign in_ready = !rec_valid_reg || rec_take;
    assign in_fire  = in_valid && in_ready;

    // Bid qualification against the robot count and the task range.
    assign robots_eff = (robot_count > RCOUNT_W'(MAX_ROBOTS)) ?
                        RCOUNT_W'(MAX_ROBOTS) : robot_count;
    assign robot_ok   = RCOUNT_W'(robot_index) < robots_eff;
    assign task_ok    = 32'(task_index) < 32'(MAX_TASKS);
    assign valid_eff  = bid_valid && robot_ok && task_ok;
    assign lc         = lc_mode && (robot_count > RCOUNT_W'(1));
    assign close_task = task_done || round_done;

    // Compares and the three possible margins run side by side.
    assign new_low     = !has_low_reg || (bid_value < low_reg);
    assign new_sec     = !has_sec_reg || (bid_value < sec_reg);
    assign margin_low  = low_reg - bid_value;
    assign margin_sec  = bid_value - low_reg;
    assign margin_keep = sec_reg - low_reg;

    // Updated task state including this beat.
    always_comb
    begin
        low_next     = low_reg;
        sec_next     = sec_reg;
        has_low_next = has_low_reg;
        has_sec_next = has_sec_reg;
        robot_next   = robot_reg;
        margin_next  = margin_keep;
        if (valid_eff)
        begin
            if (new_low)
            begin
                low_next     = bid_value;
                sec_next     = low_reg;
                has_low_next = 1'b1;
                has_sec_next = has_low_reg;
                robot_next   = robot_index;
                margin_next  = margin_low;
            end
            else if (new_sec)
            begin
                sec_next     = bid_value;
                has_sec_next = 1'b1;
                margin_next  = margin_sec;
            end
        end
    end

    // Candidate record for the winner stage.
    always_comb
    begin
        rec_ctrl_next.close = lc;
        rec_ctrl_next.rdone = round_done;
        rec_ctrl_next.unc   = lc && !has_sec_next;
        if (lc)
        begin
            rec_ctrl_next.cand = close_task && has_low_next;
            rec_bid_next       = low_next;
            rec_margin_next    = has_sec_next ? margin_next : '0;
            rec_robot_next     = robot_next;
        end
        else
        begin
            rec_ctrl_next.cand = valid_eff;
            rec_bid_next       = bid_value;
            rec_margin_next    = '0;
            rec_robot_next     = robot_index;
        end
    end

    // Task state and record control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            has_low_reg   <= 1'b0;
            has_sec_reg   <= 1'b0;
            rec_valid_reg <= 1'b0;
            rec_ctrl_reg  <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                rec_valid_reg <= 1'b1;
                rec_ctrl_reg  <= rec_ctrl_next;
                if (round_done || (lc && task_done))
                begin
                    has_low_reg <= 1'b0;
                    has_sec_reg <= 1'b0;
                end
                else if (lc)
                begin
                    has_low_reg <= has_low_next;
                    has_sec_reg <= has_sec_next;
                end
            end
            else if (rec_take)
            begin
                rec_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            if (lc)
            begin
                low_reg   <= low_next;
                sec_reg   <= sec_next;
                robot_reg <= robot_next;
            end
            rec_bid_reg    <= rec_bid_next;
            rec_margin_reg <= rec_margin_next;
            rec_robot_reg  <= rec_robot_next;
            rec_task_reg   <= task_index;
        end
    end

    assign rec_valid  = rec_valid_reg;
    assign rec_ctrl   = rec_ctrl_reg;
    assign rec_bid    = rec_bid_reg;
    assign rec_margin = rec_margin_reg;
    assign rec_robot  = rec_robot_reg;
    assign rec_task   = rec_task_reg;

endmodule : aws_task_tracker
`default_nettype wire

// ===== src/aws_winner_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aws_winner_reg
// Holds the round's running winner, folds in one candidate record per cycle
// unless a round-end record waits, and loads the result register at round end.
// ----------------------------------------------------------------------------
module aws_winner_reg
    import aws_pkg::*;
#(
    parameter int BID_W = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               rec_valid,
    output logic                    rec_take,
    input  wire rec_ctrl_t          rec_ctrl,
    input  wire logic [BID_W-1:0]   rec_bid,
    input  wire logic [BID_W-1:0]   rec_margin,
    input  wire logic [ROBOT_W-1:0] rec_robot,
    input  wire logic [TASK_W-1:0]  rec_task,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    out_found,
    output logic [ROBOT_W-1:0]      out_robot,
    output logic [TASK_W-1:0]       out_task,
    output logic [BID_W-1:0]        out_bid,
    output logic                    out_unc,
    output logic [BID_W-1:0]        out_margin
);

    // Running winner.
    logic               found_reg;
    logic [BID_W-1:0]   bid_reg;
    logic [BID_W-1:0]   margin_reg;
    logic               unc_reg;
    logic [ROBOT_W-1:0] robot_reg;
    logic [TASK_W-1:0]  task_reg;
    // Result register.
    logic               out_valid_reg;
    logic               out_found_reg;
    logic [ROBOT_W-1:0] out_robot_reg;
    logic [TASK_W-1:0]  out_task_reg;
    logic [BID_W-1:0]   out_bid_reg;
    logic               out_unc_reg;
    logic [BID_W-1:0]   out_margin_reg;

    logic               found_next;
    logic [BID_W-1:0]   bid_next;
    logic [BID_W-1:0]   margin_next;
    logic               unc_next;
    logic [ROBOT_W-1:0] robot_next;
    logic [TASK_W-1:0]  task_next;
    logic               beats;
    logic               bid_lower;
    logic               load_out;

    // A round-end record waits only while an untaken result holds the register.
    assign rec_take = rec_valid && (!rec_ctrl.rdone || !out_valid_reg || out_ready);
    assign load_out = rec_take && rec_ctrl.rdone;

    // Does the candidate beat the current winner?
    assign bid_lower = rec_bid < bid_reg;
    always_comb
    begin
        beats = 1'b0;
        if (rec_ctrl.cand)
        begin
            priority if (!found_reg)
                beats = 1'b1;
            else if (!rec_ctrl.close)
                beats = bid_lower;
            else if (rec_ctrl.unc != unc_reg)
                beats = rec_ctrl.unc;
            else if (!rec_ctrl.unc && (rec_margin != margin_reg))
                beats = rec_margin > margin_reg;
            else
                beats = bid_lower;
        end
    end

    // Winner including the current record.
    always_comb
    begin
        found_next  = found_reg;
        bid_next    = bid_reg;
        margin_next = margin_reg;
        unc_next    = unc_reg;
        robot_next  = robot_reg;
        task_next   = task_reg;
        if (beats)
        begin
            found_next  = 1'b1;
            bid_next    = rec_bid;
            margin_next = rec_margin;
            unc_next    = rec_ctrl.unc;
            robot_next  = rec_robot;
            task_next   = rec_task;
        end
    end

    // Control: winner flag and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rec_take)
            begin
                found_reg <= rec_ctrl.rdone ? 1'b0 : found_next;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Winner payload and result payload; an empty round reports all zeros.
    always_ff @(posedge clk)
    begin
        if (rec_take)
        begin
            bid_reg    <= bid_next;
            margin_reg <= margin_next;
            unc_reg    <= unc_next;
            robot_reg  <= robot_next;
            task_reg   <= task_next;
        end
        if (load_out)
        begin
            out_found_reg  <= found_next;
            out_robot_reg  <= found_next ? robot_next  : '0;
            out_task_reg   <= found_next ? task_next   : '0;
            out_bid_reg    <= found_next ? bid_next    : '0;
            out_unc_reg    <= found_next && unc_next;
            out_margin_reg <= found_next ? margin_next : '0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_found  = out_found_reg;
    assign out_robot  = out_robot_reg;
    assign out_task   = out_task_reg;
    assign out_bid    = out_bid_reg;
    assign out_unc    = out_unc_reg;
    assign out_margin = out_margin_reg;

endmodule : aws_winner_reg
`default_nettype wire

// ===== src/auction_winner_select.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// auction_winner_select
// Winner selection for one round of a sequential auction.
// ----------------------------------------------------------------------------
// The block takes one bid beat per clock cycle unless stalled and returns one
// result beat for each beat that carries tlast (round end), registered in the
// tracker's record register and then the winner stage's result register. The
// rate is set by the task tracker, which in least-contested mode folds each
// bid into the open task's lowest and second-lowest bids, and by the winner
// stage, which folds one candidate per cycle into the running winner unless a
// round-end record waits. Input keeps flowing while a result waits on the
// master side; once a further round-end beat has entered the tracker, input
// stalls until the waiting result is taken. Configuration writes are taken
// every cycle and should be made while the block is idle.
// ----------------------------------------------------------------------------
module auction_winner_select
    import aws_pkg::*;
#(
    parameter int BID_BITS = aws_pkg::BID_BITS
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Configuration write channel.
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    // Bid stream.
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // task_index[7:0], robot_index[11:8], bid_value[43:12], zero[47:44]
    input  wire logic [S_TDATA_W-1:0]   s_tdata,
    // bid_valid[0], task_done[1]
    input  wire logic [S_TUSER_W-1:0]   s_tuser,
    // round_done
    input  wire logic                   s_tlast,
    // Winner stream.
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // winner_robot[3:0], winner_task[11:4], winner_bid[43:12],
    // winner_margin[75:44], zero[79:76]
    output logic [M_TDATA_W-1:0]        m_tdata,
    // winner_found[0], winner_uncontested[1]
    output logic [M_TUSER_W-1:0]        m_tuser
);

    // Bids wider than the field carry no extra bits.
    localparam int BID_W = (BID_BITS < BID_FIELD_W) ? BID_BITS : BID_FIELD_W;

    logic                lc_mode_reg;
    logic [RCOUNT_W-1:0] robot_count_reg;

    logic               rec_valid;
    logic               rec_take;
    rec_ctrl_t          rec_ctrl;
    logic [BID_W-1:0]   rec_bid;
    logic [BID_W-1:0]   rec_margin;
    logic [ROBOT_W-1:0] rec_robot;
    logic [TASK_W-1:0]  rec_task;

    logic               out_found;
    logic [ROBOT_W-1:0] out_robot;
    logic [TASK_W-1:0]  out_task;
    logic [BID_W-1:0]   out_bid;
    logic               out_unc;
    logic [BID_W-1:0]   out_margin;

    // Configuration registers; indexes outside the list are ignored.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lc_mode_reg     <= LC_MODE_RESET;
            robot_count_reg <= ROBOT_COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_LC_MODE:     lc_mode_reg     <= cfg_data[0];
                CFG_ROBOT_COUNT: robot_count_reg <= cfg_data[RCOUNT_W-1:0];
                default:         ;
            endcase
        end
    end

    // Per-task tracking.
    aws_task_tracker #(
        .BID_W (BID_W)
    ) u_tracker (
        .clk         (clk),
        .rst_n       (rst_n),
        .lc_mode     (lc_mode_reg),
        .robot_count (robot_count_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .task_index  (s_tdata[7:0]),
        .robot_index (s_tdata[11:8]),
        .bid_value   (s_tdata[12 +: BID_W]),
        .bid_valid   (s_tuser[0]),
        .task_done   (s_tuser[1]),
        .round_done  (s_tlast),
        .rec_valid   (rec_valid),
        .rec_take    (rec_take),
        .rec_ctrl    (rec_ctrl),
        .rec_bid     (rec_bid),
        .rec_margin  (rec_margin),
        .rec_robot   (rec_robot),
        .rec_task    (rec_task)
    );

    // Round winner and result register.
    aws_winner_reg #(
        .BID_W (BID_W)
    ) u_winner (
        .clk        (clk),
        .rst_n      (rst_n),
        .rec_valid  (rec_valid),
        .rec_take   (rec_take),
        .rec_ctrl   (rec_ctrl),
        .rec_bid    (rec_bid),
        .rec_margin (rec_margin),
        .rec_robot  (rec_robot),
        .rec_task   (rec_task),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_found  (out_found),
        .out_robot  (out_robot),
        .out_task   (out_task),
        .out_bid    (out_bid),
        .out_unc    (out_unc),
        .out_margin (out_margin)
    );

    // Result beat packing.
    assign m_tdata = {4'b0000,
                      BID_FIELD_W'(out_margin),
                      BID_FIELD_W'(out_bid),
                      out_task,
                      out_robot};
    assign m_tuser = {out_unc, out_found};

endmodule : auction_winner_select
`default_nettype wire

// ===== src/aws_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aws_checker
// Port-level checks on the winner stream of the auction winner selection.
// ----------------------------------------------------------------------------
module aws_checker
    import aws_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic [M_TUSER_W-1:0] m_tuser
);

    // A stalled result beat holds its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("winner beat changed while stalled");

    // A round without a valid bid reports all fields as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> (m_tdata == '0) && !m_tuser[1])
        else $error("empty round reported nonzero fields");

    // An uncontested winner carries no margin.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> (m_tdata[75:44] == '0))
        else $error("uncontested winner with nonzero margin");

endmodule : aws_checker

bind auction_winner_select aws_checker u_aws_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
